// ===== rtl/pfa_pkg.sv =====
// Package for the page frame allocator: widths, codes and reset values.
`default_nettype none
package pfa_pkg;
	localparam int DEF_NUM_FRAMES = 64;

	localparam int OWNER_W  = 8;
	localparam int SIZE_W   = 16;
	localparam int PAGE_W   = 11;
	localparam int FC_W     = 7;
	localparam int STATUS_W = 2;
	localparam int FIDX_W   = 6;
	localparam int FREE_W   = 7;

	// pages-needed numerator: size plus page size minus one
	localparam int NUM_W     = SIZE_W + 1;
	localparam int DIV_CNT_W = $clog2(NUM_W + 1);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = PAGE_W;

	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b1;

	localparam logic [PAGE_W-1:0] PAGE_SIZE_RST   = 11'd4;
	localparam logic [FC_W-1:0]   FRAME_COUNT_RST = 7'd64;

	localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NONE    = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/page_frame_allocator.sv =====
// Top level of the first-fit page frame allocator over an occupancy bitmap.
// Flow: the free count reads one frame per cycle over the used frames while the
// pages-needed division runs alongside; the decision waits for both to finish.
// A reply or grant then goes to the output register; each scanned frame takes a read and a check state.
// Output stalls hold a reply or grant. One request at a time: a new one is taken only in idle.
// Reset: 4 KB pages, 64 frames; a clearing pass zeroes the bitmap first.
`default_nettype none
module page_frame_allocator #(
	parameter int NUM_FRAMES = pfa_pkg::DEF_NUM_FRAMES
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [pfa_pkg::OWNER_W-1:0]    owner_id,
	input  wire logic [pfa_pkg::SIZE_W-1:0]     request_size_kb,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [pfa_pkg::STATUS_W-1:0]   status,
	output logic      [pfa_pkg::FIDX_W-1:0]     frame_index,
	output logic      [pfa_pkg::OWNER_W-1:0]    owner_echo,
	output logic      [pfa_pkg::FREE_W-1:0]     free_frames,
	output logic                                last
);
	localparam int AW = $clog2(NUM_FRAMES);
	localparam int CW = $clog2(NUM_FRAMES + 1);

	typedef enum logic [6:0] {
		S_CLEAR    = 7'b0000001,
		S_IDLE     = 7'b0000010,
		S_COUNT    = 7'b0000100,
		S_DECIDE   = 7'b0001000,
		S_REPLY    = 7'b0010000,
		S_SCAN_RD  = 7'b0100000,
		S_SCAN_CHK = 7'b1000000
	} state_t;

	state_t                        state_q;
	logic [pfa_pkg::PAGE_W-1:0]    page_q;
	logic [pfa_pkg::FC_W-1:0]      fc_q;
	logic [pfa_pkg::OWNER_W-1:0]   owner_q;
	logic [CW-1:0]                 used_q;
	logic [CW-1:0]                 addr_q;
	logic [CW-1:0]                 free_q;
	logic [CW-1:0]                 grant_q;
	logic                          rdv_s1;
	logic [pfa_pkg::STATUS_W-1:0]  rep_status_q;

	logic                          out_valid_q;
	logic [pfa_pkg::STATUS_W-1:0]  status_q;
	logic [pfa_pkg::FIDX_W-1:0]    fidx_q;
	logic [pfa_pkg::OWNER_W-1:0]   oecho_q;
	logic [pfa_pkg::FREE_W-1:0]    ofree_q;
	logic                          last_q;

	logic                          accept;
	logic                          slot_free;
	logic [pfa_pkg::PAGE_W-1:0]    psize;
	logic [CW-1:0]                 used_next;
	logic [pfa_pkg::NUM_W-1:0]     numer;
	logic [pfa_pkg::NUM_W-1:0]     need;
	logic                          div_done;
	logic                          grant_last;
	logic                          mem_we;
	logic                          mem_wdata;
	logic                          rdata;
	logic                          load_rep;
	logic                          load_grant;

	assign in_ready  = state_q == S_IDLE;
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	// clamp the configuration and form the rounded-up numerator
	always_comb begin
		psize     = (page_q == '0) ? pfa_pkg::PAGE_W'(1) : page_q;
		used_next = (fc_q > pfa_pkg::FC_W'(NUM_FRAMES)) ? CW'(NUM_FRAMES) : CW'(fc_q);
		numer     = pfa_pkg::NUM_W'(request_size_kb) + pfa_pkg::NUM_W'(psize)
			- pfa_pkg::NUM_W'(1);
	end

	pfa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.numer  (numer),
		.denom  (psize),
		.quot   (need),
		.done   (div_done)
	);

	assign grant_last = (pfa_pkg::NUM_W'(grant_q) + pfa_pkg::NUM_W'(1)) == need;
	assign load_rep   = (state_q == S_REPLY) && slot_free;
	assign load_grant = (state_q == S_SCAN_CHK) && !rdata && slot_free;
	assign mem_we     = (state_q == S_CLEAR) || load_grant;
	assign mem_wdata  = state_q != S_CLEAR;

	pfa_mem #(
		.NUM_FRAMES (NUM_FRAMES),
		.AW         (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (addr_q[AW-1:0]),
		.wdata (mem_wdata),
		.raddr (addr_q[AW-1:0]),
		.rdata (rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= pfa_pkg::PAGE_SIZE_RST;
			fc_q   <= pfa_pkg::FRAME_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pfa_pkg::CFG_PAGE_SIZE:   page_q <= cfg_data;
				pfa_pkg::CFG_FRAME_COUNT: fc_q   <= cfg_data[pfa_pkg::FC_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer: clear, count, decide, then reply or scan and grant
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			addr_q       <= '0;
			free_q       <= '0;
			grant_q      <= '0;
			used_q       <= '0;
			rdv_s1       <= 1'b0;
			rep_status_q <= pfa_pkg::ST_NONE;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (addr_q == CW'(NUM_FRAMES - 1)) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + CW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						used_q  <= used_next;
						addr_q  <= '0;
						free_q  <= '0;
						rdv_s1  <= 1'b0;
						state_q <= S_COUNT;
					end
				end
				S_COUNT: begin
					if (addr_q < used_q) begin
						addr_q <= addr_q + CW'(1);
						rdv_s1 <= 1'b1;
					end else begin
						rdv_s1 <= 1'b0;
					end
					if (rdv_s1 && !rdata) begin
						free_q <= free_q + CW'(1);
					end
					if (addr_q == used_q && !rdv_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (div_done) begin
						addr_q  <= '0;
						grant_q <= '0;
						if (need == '0) begin
							rep_status_q <= pfa_pkg::ST_NONE;
							state_q      <= S_REPLY;
						end else if (need > pfa_pkg::NUM_W'(free_q)) begin
							rep_status_q <= pfa_pkg::ST_SHORT;
							state_q      <= S_REPLY;
						end else begin
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_REPLY: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					if (rdata) begin
						addr_q  <= addr_q + CW'(1);
						state_q <= S_SCAN_RD;
					end else if (slot_free) begin
						addr_q  <= addr_q + CW'(1);
						grant_q <= grant_q + CW'(1);
						state_q <= grant_last ? S_IDLE : S_SCAN_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold the owner of the request in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			owner_q <= owner_id;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_rep || load_grant) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_rep) begin
			status_q <= rep_status_q;
			fidx_q   <= '0;
			oecho_q  <= owner_q;
			ofree_q  <= pfa_pkg::FREE_W'(free_q);
			last_q   <= 1'b1;
		end else if (load_grant) begin
			status_q <= pfa_pkg::ST_GRANTED;
			fidx_q   <= pfa_pkg::FIDX_W'(addr_q[AW-1:0]);
			oecho_q  <= owner_q;
			ofree_q  <= pfa_pkg::FREE_W'(free_q);
			last_q   <= grant_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign frame_index = fidx_q;
	assign owner_echo  = oecho_q;
	assign free_frames = ofree_q;
	assign last        = last_q;

	// bitmap is written only by the clearing pass or a grant
	a_mem_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_CLEAR || state_q == S_SCAN_CHK))
		else $error("bitmap written outside clear or grant");

	// free count never runs ahead of the reads issued
	a_free_le_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COUNT) |-> (free_q <= addr_q))
		else $error("free count exceeds frames read");

	// scanning stops once every needed frame is granted
	a_grant_below_need: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_CHK) |-> (pfa_pkg::NUM_W'(grant_q) < need))
		else $error("grant count reached need while scanning");
endmodule
`default_nettype wire

// ===== rtl/pfa_div.sv =====
// Restoring divider, one quotient bit per cycle, for the pages-needed count.
`default_nettype none
module pfa_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [pfa_pkg::NUM_W-1:0]  numer,
	input  wire logic [pfa_pkg::PAGE_W-1:0] denom,
	output logic      [pfa_pkg::NUM_W-1:0]  quot,
	output logic                            done
);
	logic [pfa_pkg::NUM_W-1:0]     num_q;
	logic [pfa_pkg::PAGE_W-1:0]    den_q;
	logic [pfa_pkg::PAGE_W-1:0]    rem_q;
	logic [pfa_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [pfa_pkg::PAGE_W:0]      trial;
	logic [pfa_pkg::PAGE_W:0]      diff;
	logic                          ge;

	// shift in the next numerator bit and try the subtraction
	always_comb begin
		trial = {rem_q, num_q[pfa_pkg::NUM_W-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= pfa_pkg::DIV_CNT_W'(pfa_pkg::NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - pfa_pkg::DIV_CNT_W'(1);
			if (cnt_q == pfa_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath: remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[pfa_pkg::PAGE_W-1:0] : trial[pfa_pkg::PAGE_W-1:0];
			num_q <= {num_q[pfa_pkg::NUM_W-2:0], ge};
		end
	end

	assign quot = num_q;
	assign done = done_q;
endmodule
`default_nettype wire

// ===== rtl/pfa_mem.sv =====
// Frame occupancy bitmap: one write port, one registered read port.
`default_nettype none
module pfa_mem #(
	parameter int NUM_FRAMES = pfa_pkg::DEF_NUM_FRAMES,
	parameter int AW         = $clog2(NUM_FRAMES)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic          wdata,
	input  wire logic [AW-1:0] raddr,
	output logic               rdata
);
	logic mem [NUM_FRAMES];
	logic rdata_q;

	// write the busy bit
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire
